// ===== design/etx_pkg.sv =====
// Package for the keyword text extractor: constants, word types and register indexes.
`default_nettype none
package etx_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);
	localparam int LEN_W = 5;
	localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int CFG_DATA_W = 64;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	typedef enum logic [1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       string_end;
	} out_word_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/etx_if.sv =====
// Valid/ready channel interfaces for text input words and captured output words.
`default_nettype none
interface etx_in_if;
	import etx_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface etx_out_if;
	import etx_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// ===== design/etx_cell.sv =====
// One window cell: holds one recent byte, passes it on and compares the incoming byte.
`default_nettype none
module etx_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire etx_pkg::cell_ctl_t ctl,
	input  wire logic [7:0]        byte_in,
	input  wire logic [7:0]        kw_byte,
	input  wire logic              active,
	output logic [7:0]             byte_out,
	output logic                   hit
);
	import etx_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	// compare against the byte this cell will hold after the shift
	assign hit = !active || (byte_in == kw_byte);
	assign byte_out = byte_q;

endmodule
`default_nettype wire

// ===== design/extract_text_after_keyword_unit.sv =====
// Top level of the keyword text extractor: cell chain, mode control and output register.
//
// Usage: text bytes enter on the text channel (data_byte, last_byte), one word
// per cycle when ready is high. The keyword (1 to 16 bytes) is set through the
// write port: index 0 pattern_low, 1 pattern_high, 2 pattern_length; write only
// while the block is idle. After a keyword match, each following byte up to a
// newline comes out on the capture channel with out_valid set; a newline or the
// last byte of a buffer closes the string (string_end). A match on the last
// byte gives one empty close word.
// A result word is registered: it shows on capture in the cycle after its text
// word is taken. Throughput: one text word per cycle while ready is high; the
// window compare over the sixteen-cell byte chain and mode update end in that cycle.
// The capture side has a single output register: when it holds a word and the
// receiver stalls, text.ready drops until the word is taken.
// Reset clears the window, the eligible count and capture mode; the keyword
// resets to one zero byte. The last byte of every buffer does the same to the
// search state.
`default_nettype none
module extract_text_after_keyword_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	etx_in_if.sink                               text,
	etx_out_if.source                            capture,
	input  wire logic                            cfg_write,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [etx_pkg::CFG_DATA_W-1:0] cfg_data
);
	import etx_pkg::*;

	logic [63:0]      pattern_low_q;
	logic [63:0]      pattern_high_q;
	logic [LEN_W-1:0] pattern_length_q;

	logic [CNT_W-1:0] cnt_q;
	logic             capturing_q;
	logic             res_valid_q;
	out_word_t        res_word_q;

	logic [127:0]     keyword;
	logic [LEN_W-1:0] len_eff;
	logic             acc;
	logic [7:0]       b;
	logic             last;
	logic             is_nl;
	logic             searching;
	logic [CNT_W-1:0] cnt_nxt;
	logic             match;
	logic             cap_nxt;
	logic             has_res;
	out_word_t        res_word;
	cell_ctl_t        ctl;

	logic [7:0] chain [MAX_PATTERN_BYTES+1];
	logic [MAX_PATTERN_BYTES-1:0] hits;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data[63:0];
				CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data[63:0];
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign keyword = {pattern_high_q, pattern_low_q};

	always_comb begin
		if (pattern_length_q == '0)
			len_eff = LEN_W'(1);
		else if (pattern_length_q > LEN_W'(MAX_PATTERN_BYTES))
			len_eff = LEN_W'(MAX_PATTERN_BYTES);
		else
			len_eff = pattern_length_q;
	end

	assign acc   = text.valid && text.ready;
	assign b     = text.word.data_byte;
	assign last  = text.word.last_byte;
	assign is_nl = (b == NEWLINE_CODE);

	assign ctl.shift = acc;
	assign ctl.clear = acc && last;

	// byte chain, newest in cell 0
	assign chain[0] = b;

	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
		logic [LEN_W-1:0] kw_pos;
		logic             active;
		logic [7:0]       kw_byte;

		assign kw_pos  = len_eff - LEN_W'(i) - LEN_W'(1);
		assign active  = (LEN_W'(i) < len_eff);
		assign kw_byte = keyword[kw_pos[IDX_W-1:0]*8 +: 8];

		etx_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.byte_in  (chain[i]),
			.kw_byte  (kw_byte),
			.active   (active),
			.byte_out (chain[i+1]),
			.hit      (hits[i])
		);
	end

	// mode and eligible count
	always_comb begin
		searching = !capturing_q || is_nl;
		if (capturing_q)
			cnt_nxt = is_nl ? CNT_W'(1) : cnt_q;
		else if (cnt_q < CNT_W'(MAX_PATTERN_BYTES))
			cnt_nxt = cnt_q + CNT_W'(1);
		else
			cnt_nxt = cnt_q;
		match   = searching && (&hits) && (cnt_nxt >= CNT_W'(len_eff));
		cap_nxt = (capturing_q && !is_nl) || match;
		has_res = capturing_q || (match && last);

		res_word.out_byte   = (capturing_q && !is_nl) ? b : 8'd0;
		res_word.out_valid  = capturing_q && !is_nl;
		res_word.string_end = capturing_q ? (is_nl || last) : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			capturing_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				cnt_q       <= '0;
				capturing_q <= 1'b0;
			end else begin
				cnt_q       <= cnt_nxt;
				capturing_q <= cap_nxt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && has_res) begin
			res_valid_q <= 1'b1;
		end else if (capture.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has_res) begin
			res_word_q <= res_word;
		end
	end

	assign text.ready    = !res_valid_q || capture.ready;
	assign capture.valid = res_valid_q;
	assign capture.word  = res_word_q;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> !capturing_q && (cnt_q == '0))
		else $error("search state not cleared after last byte");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PATTERN_BYTES))
		else $error("eligible count above window size");

	a_capture_count: assert property (@(posedge clk) disable iff (!arst_n)
		capturing_q |-> (cnt_q != '0))
		else $error("capture mode without an eligible match");

	a_capture_emits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && capturing_q && !is_nl |=> capture.valid && capture.word.out_valid)
		else $error("captured byte not emitted");

endmodule
`default_nettype wire

// ===== tb/extract_text_after_keyword_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the keyword text extractor: directed cases, then random buffers.
module extract_text_after_keyword_unit_tb;
	import etx_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_WORDS = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	etx_in_if text_if ();
	etx_out_if capture_if ();

	extract_text_after_keyword_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if),
		.capture(capture_if),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// keyword settings and search state as the block should hold them
	logic [63:0] kw_lo;
	logic [63:0] kw_hi;
	logic [4:0] kw_len;
	logic [7:0] recent [MAX_PATTERN_BYTES];
	int unsigned eligible;
	bit capturing;

	in_word_t text_queue [$];
	out_word_t capture_queue [$];
	out_word_t next_capture;
	out_word_t predicted;

	int send_idle_pct;
	int recv_idle_pct;
	int unsigned cycles = 0;
	int n_queued;
	int n_accepted;
	int n_results;
	int n_strings;
	int n_settings;
	int errors;

	function automatic int keyword_len();
		int n;
		n = kw_len;
		if (n == 0) n = 1;
		if (n > MAX_PATTERN_BYTES) n = MAX_PATTERN_BYTES;
		return n;
	endfunction

	function automatic logic [7:0] keyword_byte(input int k);
		if (k < 8) return kw_lo[8*k +: 8];
		return kw_hi[8*(k-8) +: 8];
	endfunction

	function automatic void clear_search();
		foreach (recent[i]) recent[i] = 8'h00;
		eligible = 0;
		capturing = 1'b0;
	endfunction

	function automatic void shift_window(input logic [7:0] b);
		for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
		recent[0] = b;
	endfunction

	function automatic void search_shift(input logic [7:0] b, input bit fresh);
		int len;
		bit hit;
		shift_window(b);
		if (fresh) eligible = 1;
		else if (eligible < MAX_PATTERN_BYTES) eligible++;
		len = keyword_len();
		hit = (eligible >= len);
		for (int k = 0; k < len; k++) begin
			if (recent[len-1-k] != keyword_byte(k)) hit = 1'b0;
		end
		if (hit) capturing = 1'b1;
	endfunction

	// returns 1 when the word yields a capture word
	function automatic bit extract_step(input in_word_t w, output out_word_t r);
		bit produced;
		r = '0;
		produced = 1'b0;
		if (capturing) begin
			produced = 1'b1;
			if (w.data_byte == NEWLINE_CODE) begin
				r.string_end = 1'b1;
				capturing = 1'b0;
				search_shift(w.data_byte, 1'b1);
			end else begin
				r.out_byte = w.data_byte;
				r.out_valid = 1'b1;
				r.string_end = w.last_byte;
				shift_window(w.data_byte);
			end
		end else begin
			search_shift(w.data_byte, 1'b0);
			if (capturing && w.last_byte) begin
				r.string_end = 1'b1;
				produced = 1'b1;
			end
		end
		if (w.last_byte) clear_search();
		return produced;
	endfunction

	function automatic logic [7:0] noise_byte();
		int r;
		r = $urandom_range(9);
		if (r < 4) return keyword_byte($urandom_range(keyword_len() - 1));
		if (r == 4) return NEWLINE_CODE;
		return 8'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string what, input out_word_t got,
			input out_word_t want);
		$write("%0t: capture %s: got byte %02h valid %0b end %0b, ",
			$realtime, what, got.out_byte, got.out_valid, got.string_end);
		$display("want byte %02h valid %0b end %0b",
			want.out_byte, want.out_valid, want.string_end);
		errors++;
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last);
		in_word_t w;
		w.data_byte = b;
		w.last_byte = last;
		text_queue.push_back(w);
		n_queued++;
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_PATTERN_LOW: kw_lo = value;
			CFG_PATTERN_HIGH: kw_hi = value;
			default: kw_len = value[4:0];
		endcase
	endtask

	task automatic set_keyword(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] len_word);
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		write_reg(CFG_PATTERN_LENGTH, len_word);
		@(posedge clk);
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	// all words taken and all results seen, then a wait for a word with no result
	task automatic wait_idle();
		while (n_accepted != n_queued || capture_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.word <= '0;
		end else if (!text_if.valid || text_if.ready) begin
			if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				text_if.valid <= 1'b1;
				text_if.word <= text_queue.pop_front();
			end else begin
				text_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_if.ready <= 1'b0;
		end else begin
			capture_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (capture_if.valid && capture_if.ready) begin
				n_results++;
				if (capture_if.word.string_end) n_strings++;
				if (capture_queue.size() == 0) begin
					report_mismatch("word with none pending", capture_if.word, '0);
				end else begin
					next_capture = capture_queue.pop_front();
					if (capture_if.word.out_byte !== next_capture.out_byte)
						report_mismatch("out_byte", capture_if.word, next_capture);
					if (capture_if.word.out_valid !== next_capture.out_valid)
						report_mismatch("out_valid", capture_if.word, next_capture);
					if (capture_if.word.string_end !== next_capture.string_end)
						report_mismatch("string_end", capture_if.word, next_capture);
				end
			end
			if (text_if.valid && text_if.ready) begin
				if (extract_step(text_if.word, predicted)) capture_queue.push_back(predicted);
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d capture words outstanding",
				cycles, capture_queue.size());
			$display("[extract_text_after_keyword_unit] ERROR");
			$finish;
		end
	end

	initial begin
		logic [127:0] kw_bits;
		logic [63:0] len_word;
		logic [4:0] len_code;
		logic [7:0] b;
		logic [7:0] buf_q [$];
		int len;
		int cut;
		int sel;
		int phase_words;

		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.word = '0;
		capture_if.ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_PATTERN_LOW;
		cfg_data = '0;
		kw_lo = '0;
		kw_hi = '0;
		kw_len = 5'd1;
		clear_search();
		n_queued = 0;
		n_accepted = 0;
		n_results = 0;
		n_strings = 0;
		n_settings = 1;
		errors = 0;
		send_idle_pct = 9;
		recv_idle_pct = 72;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset keyword is one zero byte: match, close on newline, match on the final byte
		queue_byte(8'h00, 1'b0);
		queue_byte(NEWLINE_CODE, 1'b0);
		queue_byte(8'h00, 1'b1);
		wait_idle();

		// newline keyword via length 0: newline closes and rematches; at buffer end only the close
		len_word = {$urandom, $urandom};
		len_word[4:0] = 5'd0;
		kw_bits[63:0] = {$urandom, $urandom};
		kw_bits[7:0] = NEWLINE_CODE;
		set_keyword(kw_bits[63:0], '1, len_word);
		queue_byte(8'h78, 1'b0);
		queue_byte(NEWLINE_CODE, 1'b0);
		queue_byte(8'h79, 1'b0);
		queue_byte(NEWLINE_CODE, 1'b0);
		queue_byte(NEWLINE_CODE, 1'b1);
		wait_idle();

		// length above range acts as sixteen; final byte while capturing
		len_word = {$urandom, $urandom};
		len_word[4:0] = 5'd31;
		set_keyword({$urandom, $urandom}, {$urandom, $urandom}, len_word);
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) queue_byte(keyword_byte(k), 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES / 3) begin
				send_idle_pct = 72;
				recv_idle_pct = 9;
			end else if (p == 2 * RAND_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: len_code = 5'd16;
				1: len_code = 5'($urandom_range(17, 31));
				2: len_code = 5'd0;
				default: len_code = ($urandom_range(3) == 0) ? 5'($urandom_range(5, 16))
					: 5'($urandom_range(1, 4));
			endcase
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				sel = $urandom_range(11);
				if (p == 3) kw_bits[8*k +: 8] = 8'hFF;
				else if (sel == 0) kw_bits[8*k +: 8] = NEWLINE_CODE;
				else if (sel == 1) kw_bits[8*k +: 8] = 8'hFF;
				else if (sel == 2) kw_bits[8*k +: 8] = 8'h00;
				else kw_bits[8*k +: 8] = 8'($urandom_range(255));
			end
			len_word = {$urandom, $urandom};
			len_word[4:0] = len_code;
			set_keyword(kw_bits[63:0], kw_bits[127:64], len_word);
			len = keyword_len();
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				buf_q.delete();
				repeat ($urandom_range(1, 4)) begin
					sel = $urandom_range(9);
					if (sel < 6) begin
						for (int k = 0; k < len; k++) buf_q.push_back(keyword_byte(k));
						repeat ($urandom_range(0, 6)) begin
							b = 8'($urandom_range(255));
							if (b == NEWLINE_CODE) b = 8'h0B;
							buf_q.push_back(b);
						end
						if ($urandom_range(4) != 0) buf_q.push_back(NEWLINE_CODE);
					end else if (sel < 8) begin
						// keyword cut short, then anything
						cut = $urandom_range(len - 1);
						for (int k = 0; k < cut; k++) buf_q.push_back(keyword_byte(k));
						buf_q.push_back(noise_byte());
					end else begin
						repeat ($urandom_range(1, 5)) buf_q.push_back(noise_byte());
					end
				end
				foreach (buf_q[i]) queue_byte(buf_q[i], i == buf_q.size() - 1);
				phase_words += buf_q.size();
			end
			wait_idle();
		end

		$display("%0d text words over %0d keyword settings; %0d capture words, %0d strings closed",
			n_accepted, n_settings, n_results, n_strings);
		if (errors == 0) begin
			$display("[extract_text_after_keyword_unit] OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("[extract_text_after_keyword_unit] ERROR");
		end
		$finish;
	end

endmodule
